// ===== hdl/dns_reply_log_line_parser_unit_macros.svh =====
// assertion macros shared by the rtl
`ifndef DNS_REPLY_LOG_LINE_PARSER_UNIT_MACROS_SVH
`define DNS_REPLY_LOG_LINE_PARSER_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define DRLP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define DRLP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/drlp_pkg.sv =====
`default_nettype none

package drlp_pkg;

    // longest domain that is emitted
    localparam int DOMAIN_MAX = 64;

    // domain store geometry
    localparam int STORE_DEPTH = 64;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    // parse phases
    localparam logic [2:0] PH_SEARCH  = 3'd0;
    localparam logic [2:0] PH_GAP_DOM = 3'd1;
    localparam logic [2:0] PH_DOMAIN  = 3'd2;
    localparam logic [2:0] PH_GAP_IS  = 3'd3;
    localparam logic [2:0] PH_IS      = 3'd4;
    localparam logic [2:0] PH_GAP_VAL = 3'd5;
    localparam logic [2:0] PH_VALUE   = 3'd6;
    localparam logic [2:0] PH_DONE    = 3'd7;

    // keyword lengths
    localparam logic [2:0] KW_REPLY_LEN = 3'd5;
    localparam logic [2:0] KW_IS_LEN    = 3'd2;

    // character codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    localparam logic [9:0] OCTET_MAX = 10'd255;

    // letter of "reply" at a position
    function automatic logic [7:0] kw_reply_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h72;
            3'd1:    ch = 8'h65;
            3'd2:    ch = 8'h70;
            3'd3:    ch = 8'h6C;
            3'd4:    ch = 8'h79;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // letter of "is" at a position
    function automatic logic [7:0] kw_is_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h69;
            3'd1:    ch = 8'h73;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/dns_reply_log_line_parser_unit.sv =====
// timing: a line byte is handled in the cycle it is accepted; after the final byte of a line is taken
//   its first result passes the domain memory read register into the output register, a rejected
//   line's beat is loaded there directly, and the rest follow one per cycle unless stalled
// throughput: one byte per cycle while parsing; after the final byte char_stall is high
//   until the last result of the line is loaded into the output register, also while result_stall holds it
// reset: parser and emitter return to idle; the domain memory is not cleared
`default_nettype none

module dns_reply_log_line_parser_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        char_valid,
    output logic             char_stall,
    input  wire logic [7:0]  char_byte,
    input  wire logic        end_of_line,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic             valid_res,
    output logic [7:0]       domain_char,
    output logic [31:0]      ipv4_address,
    output logic             last
);
    import drlp_pkg::*;

    `include "dns_reply_log_line_parser_unit_macros.svh"

    // top state codes
    localparam logic ST_PARSE = 1'b0;
    localparam logic ST_EMIT  = 1'b1;

    logic state_reg, state_next;

    // parser state
    logic [2:0]  phase_reg, phase_next;
    logic [2:0]  kw_count_reg, kw_count_next;
    logic        word_start_reg, word_start_next;
    logic [6:0]  dom_len_reg, dom_len_next;
    logic        dom_dot_reg, dom_dot_next;
    logic [9:0]  oct_val_reg, oct_val_next;
    logic [1:0]  oct_dig_reg, oct_dig_next;
    logic [2:0]  oct_cnt_reg, oct_cnt_next;
    logic [31:0] addr_reg, addr_next;
    logic        rej_reg, rej_next;

    // emitter state
    logic [6:0]  emit_len_reg, emit_len_next;
    logic [6:0]  emit_idx_reg, emit_idx_next;
    logic        emit_rej_reg, emit_rej_next;
    logic [31:0] emit_addr_reg, emit_addr_next;
    logic        rd_pend_reg, rd_pend_next;
    logic        rd_last_reg, rd_last_next;

    // output register
    logic        res_valid_reg, res_valid_next;
    logic        res_ok_reg, res_ok_next;
    logic [7:0]  res_char_reg, res_char_next;
    logic [31:0] res_addr_reg, res_addr_next;
    logic        res_last_reg, res_last_next;

    // domain memory
    logic [7:0]          domain_mem [STORE_DEPTH];
    logic [7:0]          mem_rd_data_reg;
    logic                wr_en;
    logic [STORE_AW-1:0] wr_addr;
    logic [7:0]          wr_data;
    logic                rd_en;
    logic [STORE_AW-1:0] rd_addr;

    logic byte_acc;
    logic out_free;
    logic load_out;
    logic issue;

    assign char_stall   = (state_reg != ST_PARSE);
    assign byte_acc     = char_valid && !char_stall;
    assign out_free     = !res_valid_reg || !result_stall;
    assign result_valid = res_valid_reg;
    assign valid_res    = res_ok_reg;
    assign domain_char  = res_char_reg;
    assign ipv4_address = res_addr_reg;
    assign last         = res_last_reg;

    // line parser: handle one byte, then close the line on cr, lf or final byte
    always_comb
    begin
        logic [2:0]  ph;
        logic [2:0]  kc;
        logic        ws;
        logic [6:0]  dl;
        logic        dd;
        logic [9:0]  ov;
        logic [1:0]  od;
        logic [2:0]  oc;
        logic [31:0] ac;
        logic        rj;
        logic        sp;
        logic        crlf;
        logic        is_digit;
        logic        dom_b;
        logic        val_b;
        logic        kw_b;
        logic        kw_reply;
        logic [7:0]  kw_ch;
        logic [2:0]  kw_len;
        logic [7:0]  c;
        logic [6:0]  eff;

        ph = phase_reg;
        kc = kw_count_reg;
        ws = word_start_reg;
        dl = dom_len_reg;
        dd = dom_dot_reg;
        ov = oct_val_reg;
        od = oct_dig_reg;
        oc = oct_cnt_reg;
        ac = addr_reg;
        rj = rej_reg;
        c  = char_byte;
        sp = (c == CH_SPACE) || (c == CH_TAB);
        crlf = (c == CH_CR) || (c == CH_LF);
        is_digit = c inside {[CH_ZERO:CH_NINE]};
        dom_b = 1'b0;
        val_b = 1'b0;
        kw_b = 1'b0;
        kw_reply = 1'b0;
        kw_ch = 8'd0;
        kw_len = KW_REPLY_LEN;
        wr_en = 1'b0;
        wr_addr = dl[STORE_AW-1:0];
        wr_data = (c inside {[CH_UP_A:CH_UP_Z]}) ? c + CASE_OFS : c;

        // phase step for an ordinary byte
        if (!crlf && ph != PH_DONE)
        begin
            case (ph)
                PH_SEARCH:
                begin
                    if (sp)
                    begin
                        if (ws && kc == KW_REPLY_LEN)
                        begin
                            ph = PH_GAP_DOM;
                        end
                        else
                        begin
                            ws = 1'b1;
                            kc = 3'd0;
                        end
                    end
                    else
                    begin
                        kw_b = 1'b1;
                        kw_reply = 1'b1;
                    end
                end
                PH_GAP_DOM:
                begin
                    if (!sp)
                    begin
                        ph = PH_DOMAIN;
                        dom_b = 1'b1;
                    end
                end
                PH_DOMAIN:
                begin
                    if (sp)
                    begin
                        ph = PH_GAP_IS;
                    end
                    else
                    begin
                        dom_b = 1'b1;
                    end
                end
                PH_GAP_IS:
                begin
                    if (!sp)
                    begin
                        ph = PH_IS;
                        ws = 1'b1;
                        kc = 3'd0;
                        kw_b = 1'b1;
                    end
                end
                PH_IS:
                begin
                    if (sp)
                    begin
                        if (ws && kc == KW_IS_LEN)
                        begin
                            ph = PH_GAP_VAL;
                        end
                        else
                        begin
                            rj = 1'b1;
                            ph = PH_DONE;
                        end
                    end
                    else
                    begin
                        kw_b = 1'b1;
                    end
                end
                PH_GAP_VAL:
                begin
                    if (!sp)
                    begin
                        ph = PH_VALUE;
                        val_b = 1'b1;
                    end
                end
                PH_VALUE:
                begin
                    if (sp)
                    begin
                        // end of value token
                        if (od == 2'd0 || ov > OCTET_MAX)
                        begin
                            rj = 1'b1;
                        end
                        else
                        begin
                            ac = {ac[23:0], ov[7:0]};
                            oc = oc + 3'd1;
                            od = 2'd0;
                            ov = 10'd0;
                            if (oc != 3'd4)
                            begin
                                rj = 1'b1;
                            end
                        end
                        ph = PH_DONE;
                    end
                    else
                    begin
                        val_b = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase

            // keyword letter match
            if (kw_b)
            begin
                kw_ch  = kw_reply ? kw_reply_char(kc) : kw_is_char(kc);
                kw_len = kw_reply ? KW_REPLY_LEN : KW_IS_LEN;
                if (ws && kc < kw_len && c == kw_ch)
                begin
                    kc = kc + 3'd1;
                end
                else
                begin
                    ws = 1'b0;
                end
            end

            // domain byte into the store
            if (dom_b)
            begin
                if (dl > 7'(DOMAIN_MAX))
                begin
                    rj = 1'b1;
                    ph = PH_DONE;
                end
                else
                begin
                    wr_en = (dl < 7'(DOMAIN_MAX));
                    dl = dl + 7'd1;
                    dd = (c == CH_DOT);
                end
            end

            // value byte
            if (val_b)
            begin
                if (is_digit)
                begin
                    if (od == 2'd3)
                    begin
                        rj = 1'b1;
                        ph = PH_DONE;
                    end
                    else
                    begin
                        ov = (ov << 3) + (ov << 1) + {2'b00, c - CH_ZERO};
                        od = od + 2'd1;
                    end
                end
                else if (c == CH_DOT)
                begin
                    if (od == 2'd0 || ov > OCTET_MAX)
                    begin
                        rj = 1'b1;
                        ph = PH_DONE;
                    end
                    else
                    begin
                        ac = {ac[23:0], ov[7:0]};
                        oc = oc + 3'd1;
                        od = 2'd0;
                        ov = 10'd0;
                        if (oc >= 3'd4)
                        begin
                            rj = 1'b1;
                            ph = PH_DONE;
                        end
                    end
                end
                else
                begin
                    rj = 1'b1;
                    ph = PH_DONE;
                end
            end
        end

        // close the line
        if (crlf || end_of_line)
        begin
            if (ph == PH_VALUE)
            begin
                if (od == 2'd0 || ov > OCTET_MAX)
                begin
                    rj = 1'b1;
                end
                else
                begin
                    ac = {ac[23:0], ov[7:0]};
                    oc = oc + 3'd1;
                    od = 2'd0;
                    ov = 10'd0;
                    if (oc != 3'd4)
                    begin
                        rj = 1'b1;
                    end
                end
                ph = PH_DONE;
            end
            else if (ph != PH_DONE)
            begin
                rj = 1'b1;
                ph = PH_DONE;
            end
        end

        phase_next      = ph;
        kw_count_next   = kc;
        word_start_next = ws;
        dom_len_next    = dl;
        dom_dot_next    = dd;
        oct_val_next    = ov;
        oct_dig_next    = od;
        oct_cnt_next    = oc;
        addr_next       = ac;
        rej_next        = rj;

        // emission setup for the final byte
        eff = (dl != 7'd0 && dd) ? dl - 7'd1 : dl;
        emit_len_next  = eff;
        emit_rej_next  = rj || (eff == 7'd0) || (eff > 7'(DOMAIN_MAX));
        emit_addr_next = ac;

        if (!byte_acc)
        begin
            wr_en = 1'b0;
        end
    end

    // emitter: prefetch one entry ahead of the output register
    always_comb
    begin
        state_next     = state_reg;
        emit_idx_next  = emit_idx_reg;
        rd_pend_next   = rd_pend_reg;
        rd_last_next   = rd_last_reg;
        res_valid_next = res_valid_reg && result_stall;
        res_ok_next    = res_ok_reg;
        res_char_next  = res_char_reg;
        res_addr_next  = res_addr_reg;
        res_last_next  = res_last_reg;
        load_out       = 1'b0;
        issue          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = emit_idx_reg[STORE_AW-1:0];

        if (state_reg == ST_PARSE)
        begin
            if (byte_acc && end_of_line)
            begin
                state_next    = ST_EMIT;
                emit_idx_next = 7'd0;
                rd_pend_next  = 1'b0;
            end
        end
        else if (emit_rej_reg)
        begin
            // single rejection beat
            if (out_free)
            begin
                res_valid_next = 1'b1;
                res_ok_next    = 1'b0;
                res_char_next  = 8'd0;
                res_addr_next  = 32'd0;
                res_last_next  = 1'b1;
                state_next     = ST_PARSE;
            end
        end
        else
        begin
            load_out = rd_pend_reg && out_free;
            issue    = (emit_idx_reg < emit_len_reg) && (!rd_pend_reg || load_out);
            if (load_out)
            begin
                res_valid_next = 1'b1;
                res_ok_next    = 1'b1;
                res_char_next  = mem_rd_data_reg;
                res_addr_next  = emit_addr_reg;
                res_last_next  = rd_last_reg;
                rd_pend_next   = 1'b0;
                if (rd_last_reg)
                begin
                    state_next = ST_PARSE;
                end
            end
            if (issue)
            begin
                rd_en         = 1'b1;
                emit_idx_next = emit_idx_reg + 7'd1;
                rd_last_next  = (emit_idx_reg + 7'd1 == emit_len_reg);
                rd_pend_next  = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_PARSE;
            phase_reg      <= PH_SEARCH;
            kw_count_reg   <= 3'd0;
            word_start_reg <= 1'b1;
            dom_len_reg    <= 7'd0;
            dom_dot_reg    <= 1'b0;
            oct_val_reg    <= 10'd0;
            oct_dig_reg    <= 2'd0;
            oct_cnt_reg    <= 3'd0;
            addr_reg       <= 32'd0;
            rej_reg        <= 1'b0;
            emit_idx_reg   <= 7'd0;
            rd_pend_reg    <= 1'b0;
            rd_last_reg    <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            emit_idx_reg  <= emit_idx_next;
            rd_pend_reg   <= rd_pend_next;
            rd_last_reg   <= rd_last_next;
            res_valid_reg <= res_valid_next;
            if (byte_acc)
            begin
                if (end_of_line)
                begin
                    // back to a fresh line
                    phase_reg      <= PH_SEARCH;
                    kw_count_reg   <= 3'd0;
                    word_start_reg <= 1'b1;
                    dom_len_reg    <= 7'd0;
                    dom_dot_reg    <= 1'b0;
                    oct_val_reg    <= 10'd0;
                    oct_dig_reg    <= 2'd0;
                    oct_cnt_reg    <= 3'd0;
                    addr_reg       <= 32'd0;
                    rej_reg        <= 1'b0;
                end
                else
                begin
                    phase_reg      <= phase_next;
                    kw_count_reg   <= kw_count_next;
                    word_start_reg <= word_start_next;
                    dom_len_reg    <= dom_len_next;
                    dom_dot_reg    <= dom_dot_next;
                    oct_val_reg    <= oct_val_next;
                    oct_dig_reg    <= oct_dig_next;
                    oct_cnt_reg    <= oct_cnt_next;
                    addr_reg       <= addr_next;
                    rej_reg        <= rej_next;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (byte_acc && end_of_line)
        begin
            emit_len_reg  <= emit_len_next;
            emit_rej_reg  <= emit_rej_next;
            emit_addr_reg <= emit_addr_next;
        end
        res_ok_reg   <= res_ok_next;
        res_char_reg <= res_char_next;
        res_addr_reg <= res_addr_next;
        res_last_reg <= res_last_next;
    end

    // domain memory, writes while parsing and reads while emitting
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            domain_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_rd_data_reg <= domain_mem[rd_addr];
        end
    end

    // checks
    `DRLP_ASSERT_SAME(a_no_write_in_emit, state_reg == ST_EMIT, !wr_en, "memory written during emission")
    `DRLP_ASSERT_SAME(a_no_read_in_parse, state_reg == ST_PARSE, !rd_en, "memory read while parsing")
    `DRLP_ASSERT_NEXT(a_eol_enters_emit, byte_acc && end_of_line, state_reg == ST_EMIT, "final byte did not start emission")
    `DRLP_ASSERT_SAME(a_reject_beat, result_valid && !valid_res, last && domain_char == 8'd0 && ipv4_address == 32'd0, "malformed rejection beat")
    `DRLP_ASSERT_SAME(a_idx_bound, state_reg == ST_EMIT && !emit_rej_reg, emit_idx_reg <= emit_len_reg, "emission index past domain length")

endmodule

`default_nettype wire
